// ----- sv/lsb_stego_frame_extractor_core_assert.svh -----
// assertion macros for the frame extractor
`ifndef LSB_STEGO_FRAME_EXTRACTOR_CORE_ASSERT_SVH
`define LSB_STEGO_FRAME_EXTRACTOR_CORE_ASSERT_SVH

// property checked at every clock outside reset
`define LSFE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define LSFE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/lsfe_pkg.sv -----
`default_nettype none
package lsfe_pkg;

   localparam int SIZE_FIELD_BITS = 32;
   localparam int LEN_W           = SIZE_FIELD_BITS + 2;
   localparam int CNT_W           = SIZE_FIELD_BITS + 1;
   localparam int BIT_CNT_W       = $clog2(SIZE_FIELD_BITS);
   localparam int BITS_PER_BEAT   = 3;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

   localparam logic KIND_NAME    = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   typedef enum logic [2:0] {
      PH_TOTAL,
      PH_NAMELEN,
      PH_NAME,
      PH_PAYLOAD,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [7:0] chan0;
      logic [7:0] chan1;
      logic [7:0] chan2;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_kind;
      logic       last_byte;
   } rsp_type;

   typedef struct packed {
      logic                     valid;
      logic [BITS_PER_BEAT-1:0] bits;
   } beat_type;

   typedef struct packed {
      phase_type phase;
      logic      pop;
   } dec_status_type;

endpackage
`default_nettype wire

// ----- sv/lsfe_front.sv -----
`default_nettype none
module lsfe_front
   import lsfe_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire req_type  req_data,
   output beat_type      beat,
   input  wire logic     beat_ready
);

   logic [BITS_PER_BEAT-1:0] q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]        cnt_ff, cnt_in;
   logic                     push;
   logic                     pop;

   assign req_ready  = (cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign push       = req_valid && req_ready;
   assign beat.valid = (cnt_ff != '0);
   assign beat.bits  = q_ff[rd_ptr_ff];
   assign pop        = beat.valid && beat_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (!push && pop) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // keep only the hidden bits, chan0 first
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= {req_data.chan2[0], req_data.chan1[0], req_data.chan0[0]};
      end
   end

endmodule
`default_nettype wire

// ----- sv/lsfe_back.sv -----
`default_nettype none
module lsfe_back
   import lsfe_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire beat_type beat,
   output logic          beat_ready,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output rsp_type       rsp_data,
   output dec_status_type status
);

   typedef struct packed {
      phase_type                  phase;
      logic [BIT_CNT_W-1:0]       bit_count;
      logic [SIZE_FIELD_BITS-1:0] field;
      logic [7:0]                 accum;
      logic [CNT_W-1:0]           remain;
      logic [LEN_W-1:0]           tot_m8;
      logic [CNT_W-1:0]           pay;
      logic                       pay_ok;
   } dec_type;

   typedef struct packed {
      dec_type st;
      logic    emit;
      rsp_type rsp;
   } step_type;

   function automatic step_type dec_step(step_type s, logic b);
      step_type                   r;
      logic [SIZE_FIELD_BITS-1:0] f;
      logic [LEN_W-1:0]           fval;
      logic [LEN_W-1:0]           plen;
      logic [7:0]                 acc;
      r    = s;
      f    = {b, s.st.field[SIZE_FIELD_BITS-1:1]};
      fval = {{(LEN_W - SIZE_FIELD_BITS){f[SIZE_FIELD_BITS-1]}}, f};
      plen = s.st.tot_m8 - fval;
      acc  = {b, s.st.accum[7:1]};
      case (s.st.phase)
         PH_TOTAL, PH_NAMELEN: begin
            r.st.field = f;
            if (s.st.bit_count == BIT_CNT_W'(SIZE_FIELD_BITS - 1)) begin
               r.st.bit_count = '0;
               if (s.st.phase == PH_TOTAL) begin
                  r.st.tot_m8 = fval - LEN_W'(8);
                  r.st.phase  = PH_NAMELEN;
               end else begin
                  r.st.pay    = plen[CNT_W-1:0];
                  r.st.pay_ok = !plen[LEN_W-1] && (plen != '0);
                  if (!fval[LEN_W-1] && (fval != '0)) begin
                     r.st.phase  = PH_NAME;
                     r.st.remain = fval[CNT_W-1:0];
                  end else if (!plen[LEN_W-1] && (plen != '0)) begin
                     r.st.phase  = PH_PAYLOAD;
                     r.st.remain = plen[CNT_W-1:0];
                  end else begin
                     r.st.phase = PH_DONE;
                  end
               end
            end else begin
               r.st.bit_count = s.st.bit_count + BIT_CNT_W'(1);
            end
         end
         PH_NAME, PH_PAYLOAD: begin
            r.st.accum = acc;
            if (s.st.bit_count == BIT_CNT_W'(7)) begin
               r.st.bit_count     = '0;
               r.st.remain        = s.st.remain - CNT_W'(1);
               r.emit             = 1'b1;
               r.rsp.data_byte    = acc;
               r.rsp.byte_kind    = (s.st.phase == PH_PAYLOAD) ? KIND_PAYLOAD : KIND_NAME;
               r.rsp.last_byte    = 1'b0;
               if (s.st.remain == CNT_W'(1)) begin
                  if (s.st.phase == PH_PAYLOAD) begin
                     r.rsp.last_byte = 1'b1;
                     r.st.phase      = PH_DONE;
                  end else if (s.st.pay_ok) begin
                     r.st.phase  = PH_PAYLOAD;
                     r.st.remain = s.st.pay;
                  end else begin
                     r.st.phase = PH_DONE;
                  end
               end
            end else begin
               r.st.bit_count = s.st.bit_count + BIT_CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   dec_type  st_ff, st_in;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_data_ff, rsp_data_in;
   step_type stp [BITS_PER_BEAT + 1];
   logic     pop;

   // next state: one decode step per hidden bit
   always_comb begin
      stp[0].st   = st_ff;
      stp[0].emit = 1'b0;
      stp[0].rsp  = '0;
      for (int i = 0; i < BITS_PER_BEAT; i++) begin
         stp[i + 1] = dec_step(stp[i], beat.bits[i]);
      end
      st_in = stp[BITS_PER_BEAT].st;
   end

   // outputs and result register
   always_comb begin
      pop          = beat.valid && (!rsp_valid_ff || rsp_ready);
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (pop) begin
         rsp_valid_in = stp[BITS_PER_BEAT].emit;
         if (stp[BITS_PER_BEAT].emit) begin
            rsp_data_in = stp[BITS_PER_BEAT].rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.phase     <= PH_TOTAL;
         st_ff.bit_count <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (pop) begin
            st_ff <= st_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign beat_ready   = pop;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;
   assign status.phase = st_ff.phase;
   assign status.pop   = pop;

endmodule
`default_nettype wire

// ----- sv/lsb_stego_frame_extractor_core.sv -----
// lsb_stego_frame_extractor_core
// recovers a frame hidden in the pixel LSBs: size, name length, name bytes, payload
// req channel: one pixel per beat (chan0, chan1, chan2), LSB of each taken in that order
// rsp channel: one recovered byte per beat, byte_kind 0 for name, 1 for payload,
//   last_byte set on the final payload byte
// throughput: one pixel per cycle while rsp is not stalled; at most one byte comes out per pixel
// path: a byte completed by a pixel goes from that pixel's beat through the two-entry
//   bit queue, then the three-step decoder into the rsp register
// after the last payload byte, or for an empty frame, pixels are accepted and dropped
// reset: decoder returns to the total size field, queue and rsp register empty
// rsp stall: the rsp register holds its beat; the decoder stops while it is full,
//   the bit queue keeps taking pixels until both entries are used, then req_ready drops
`default_nettype none
`include "lsb_stego_frame_extractor_core_assert.svh"
module lsb_stego_frame_extractor_core
   import lsfe_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   beat_type       beat;
   logic           beat_ready;
   dec_status_type status;

   lsfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .beat       (beat),
      .beat_ready (beat_ready)
   );

   lsfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .beat       (beat),
      .beat_ready (beat_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .status     (status)
   );

   `LSFE_ASSERT(a_last_is_payload, (rsp_valid && rsp_data.last_byte) |-> (rsp_data.byte_kind == KIND_PAYLOAD), "last byte flagged on a name byte")
   `LSFE_ASSERT(a_last_means_done, (rsp_valid && rsp_data.last_byte) |-> (status.phase == PH_DONE), "decoder not done after last byte")
   `LSFE_ASSERT_NEXT(a_done_is_silent, (status.phase == PH_DONE) && !rsp_valid, !rsp_valid, "byte produced after frame end")
   `LSFE_ASSERT(a_pop_needs_room, status.pop |-> (!rsp_valid || rsp_ready), "decoder advanced into a full rsp register")

endmodule
`default_nettype wire
